// File: hw/rtl/nmeacs_pkg.sv
// Package for the NMEA sentence checksum validator: byte codes, status codes,
// beat payload types and the hex digit decoder.
// No dependencies; the result buffer, the validator and the testbench import it.
`timescale 1ns / 1ps

package nmeacs_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;

  localparam logic [7:0] MaxLenReset = 8'd82;
  localparam logic [7:0] LenSat      = 8'hFF;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusMismatch = 3'd1,
    StatusNonHex   = 3'd2,
    StatusNoStar   = 3'd3,
    StatusTooLong  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_in;
  } char_beat_t;

  typedef struct packed {
    logic       sentence_ok;
    status_e    status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_beat_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes one uppercase hex digit; valid is low for any other byte.
  function automatic hex_digit_t hex_decode(logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b0;
    d.value = 4'd0;
    if (c >= CharZero && c <= CharNine) begin
      d.valid = 1'b1;
      d.value = c[3:0];
    end else if (c >= CharUpperA && c <= CharUpperF) begin
      d.valid = 1'b1;
      d.value = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/nmeacs_stream_if.sv
// Valid/ready stream interface used for the byte input and the result output.
// Payload type is a parameter; the payload structs come from nmeacs_pkg.
`timescale 1ns / 1ps

interface nmeacs_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/nmeacs_out_buf.sv
// Two-entry result buffer: an output register plus a skid register.
// Depends on nmeacs_pkg and nmeacs_stream_if.
`timescale 1ns / 1ps

module nmeacs_out_buf
  import nmeacs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  result_beat_t         data_i,
  output logic                 ready_o,
  nmeacs_stream_if.source      res_o
);

  result_beat_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         pop;

  // Ready only looks at the skid register, so it never depends on the output side.
  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && res_o.ready;

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready && push_i) |=> skid_valid_q)
    else $error("stalled result beat was dropped");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("result pushed while buffer is full");

endmodule

// File: hw/rtl/nmea_sentence_checksum_validator.sv
// NMEA 0183 sentence checksum validator, top level.
// A carriage return beat's result is registered in the result buffer before it is shown.
// Throughput: one byte beat per cycle; the two-entry result buffer sets the only stall,
// which lasts while both of its entries are held by a stalled output.
// Reset (rst_ni, asynchronous, active low) leaves no sentence open and the length limit at 82.
// Depends on nmeacs_pkg, nmeacs_stream_if and nmeacs_out_buf.
`timescale 1ns / 1ps

module nmea_sentence_checksum_validator
  import nmeacs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  nmeacs_stream_if.sink    char_i,
  nmeacs_stream_if.source  res_o
);

  logic [7:0]   max_len_q;
  logic         in_sentence_q, in_sentence_d;
  logic         star_seen_q, star_seen_d;
  logic [7:0]   xor_acc_q, xor_acc_d;
  logic [7:0]   len_q, len_d;
  logic [15:0]  last_two_q, last_two_d;

  logic         buf_ready;
  logic         accept;
  logic         push;
  logic [7:0]   c;
  logic [7:0]   len_inc;
  hex_digit_t   hi_dig, lo_dig;
  result_beat_t result;

  assign c      = char_i.payload.char_in;
  assign accept = char_i.valid && buf_ready;
  assign char_i.ready = buf_ready;

  assign len_inc = (len_q == LenSat) ? len_q : len_q + 8'd1;
  assign push    = accept && in_sentence_q && (c != CharDollar) && (c == CharCr);

  always_comb begin
    in_sentence_d = in_sentence_q;
    star_seen_d   = star_seen_q;
    xor_acc_d     = xor_acc_q;
    len_d         = len_q;
    last_two_d    = last_two_q;
    if (accept) begin
      if (c == CharDollar) begin
        in_sentence_d = 1'b1;
        star_seen_d   = 1'b0;
        xor_acc_d     = 8'd0;
        len_d         = 8'd1;
        last_two_d    = {8'd0, CharDollar};
      end else if (in_sentence_q) begin
        len_d = len_inc;
        if (c == CharCr) begin
          in_sentence_d = 1'b0;
        end else begin
          if (!star_seen_q) begin
            if (c == CharStar) begin
              star_seen_d = 1'b1;
            end else begin
              xor_acc_d = xor_acc_q ^ c;
            end
          end
          last_two_d = {last_two_q[7:0], c};
        end
      end
    end
  end

  // Result for a carriage return, built from the state before that byte.
  always_comb begin
    hi_dig = hex_decode(last_two_q[15:8]);
    lo_dig = hex_decode(last_two_q[7:0]);
    result.computed_sum = xor_acc_q;
    result.received_sum = (hi_dig.valid && lo_dig.valid) ? {hi_dig.value, lo_dig.value}
                                                         : 8'd0;
    if (len_inc > max_len_q) begin
      result.status = StatusTooLong;
    end else if (!(hi_dig.valid && lo_dig.valid)) begin
      result.status = StatusNonHex;
    end else if (!star_seen_q) begin
      result.status = StatusNoStar;
    end else if (result.received_sum != xor_acc_q) begin
      result.status = StatusMismatch;
    end else begin
      result.status = StatusOk;
    end
    result.sentence_ok = (result.status == StatusOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q     <= MaxLenReset;
      in_sentence_q <= 1'b0;
      star_seen_q   <= 1'b0;
      xor_acc_q     <= 8'd0;
      len_q         <= 8'd0;
      last_two_q    <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      in_sentence_q <= in_sentence_d;
      star_seen_q   <= star_seen_d;
      xor_acc_q     <= xor_acc_d;
      len_q         <= len_d;
      last_two_q    <= last_two_d;
    end
  end

  nmeacs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (buf_ready),
    .res_o   (res_o)
  );

  a_cr_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> res_o.valid)
    else $error("carriage return in a sentence gave no result beat");

  a_dollar_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && c == CharDollar) |=> (in_sentence_q && len_q == 8'd1 && !star_seen_q))
    else $error("dollar did not open a fresh sentence");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sentence_q |-> (len_q != 8'd0))
    else $error("open sentence with zero length");

  a_cr_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !in_sentence_q)
    else $error("sentence still open after carriage return");

endmodule

// File: tb/tb_nmea_sentence_checksum_validator.sv
// Self-checking testbench for nmea_sentence_checksum_validator: directed sentences,
// then random sentences and noise under changing length limits and back-pressure.
// Depends on nmeacs_pkg, nmeacs_stream_if and the validator RTL.
`timescale 1ns / 1ps

module tb_nmea_sentence_checksum_validator;
  import nmeacs_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct {
    string        txt;
    logic [7:0]   tail;
    logic         typed;
    result_beat_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  nmeacs_stream_if #(.payload_t(char_beat_t))   char_if ();
  nmeacs_stream_if #(.payload_t(result_beat_t)) res_if ();

  nmea_sentence_checksum_validator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .char_i     (char_if),
    .res_o      (res_if)
  );

  // Sentence tracking state, kept in step with every accepted byte beat.
  logic       in_sent;
  logic       star_seen;
  logic [7:0] run_xor;
  logic [7:0] len_cnt;
  logic [15:0] last_pair;
  logic [7:0] len_limit;

  result_beat_t expected_sentences[$];
  logic         use_typed;
  result_beat_t typed_result;

  int error_count;
  int cycle_count;
  int useful_bytes;
  int sentences_closed;
  int send_idle;
  int recv_idle;

  // Short rows whose result is obvious carry it typed in; the rest go to the predictor.
  dir_row_t dir_rows [12] = '{
    '{"$*00",        CharCr, 1'b1, '{1'b1, StatusOk,       8'h00, 8'h00}},
    '{"$A*42",       CharCr, 1'b1, '{1'b0, StatusMismatch, 8'h41, 8'h42}},
    '{"$A*4a",       CharCr, 1'b1, '{1'b0, StatusNonHex,   8'h41, 8'h00}},
    '{"$AB",         CharCr, 1'b1, '{1'b0, StatusNoStar,   8'h03, 8'hAB}},
    '{"$",           CharCr, 1'b1, '{1'b0, StatusNonHex,   8'h00, 8'h00}},
    '{"q",           CharCr, 1'b0, '{1'b0, StatusOk,       8'h00, 8'h00}},
    '{"$",           8'hFF,  1'b0, '{1'b0, StatusOk,       8'h00, 8'h00}},
    '{"*FF",         CharCr, 1'b1, '{1'b1, StatusOk,       8'hFF, 8'hFF}},
    '{"",            8'h00,  1'b0, '{1'b0, StatusOk,       8'h00, 8'h00}},
    '{"$A$*00",      CharCr, 1'b1, '{1'b1, StatusOk,       8'h00, 8'h00}},
    '{"$9*39",       CharCr, 1'b1, '{1'b1, StatusOk,       8'h39, 8'h39}},
    '{"$GPGLL,A*5C", CharCr, 1'b0, '{1'b0, StatusOk,       8'h00, 8'h00}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Returns {is_digit, value} for an uppercase hex digit.
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return {1'b1, 4'(c - CharZero)};
    if (c >= CharUpperA && c <= CharUpperF) return {1'b1, 4'(c - CharUpperA + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CharZero + 8'(n) : CharUpperA + 8'(n) - 8'd10;
  endfunction

  task automatic predict_nmea_byte(input logic [7:0] c);
    logic [4:0]   hi;
    logic [4:0]   lo;
    result_beat_t r;
    status_e      st;
    if (c == CharDollar) begin
      in_sent   = 1'b1;
      star_seen = 1'b0;
      run_xor   = 8'h00;
      len_cnt   = 8'd1;
      last_pair = {8'h00, CharDollar};
      useful_bytes++;
      return;
    end
    if (!in_sent) return;
    useful_bytes++;
    if (len_cnt != LenSat) len_cnt++;
    if (c == CharCr) begin
      hi = hex_digit_value(last_pair[15:8]);
      lo = hex_digit_value(last_pair[7:0]);
      r.received_sum = (hi[4] && lo[4]) ? {hi[3:0], lo[3:0]} : 8'h00;
      if (len_cnt > len_limit) st = StatusTooLong;
      else if (!(hi[4] && lo[4])) st = StatusNonHex;
      else if (!star_seen) st = StatusNoStar;
      else if (r.received_sum != run_xor) st = StatusMismatch;
      else st = StatusOk;
      r.status       = st;
      r.sentence_ok  = (st == StatusOk);
      r.computed_sum = run_xor;
      expected_sentences.push_back(use_typed ? typed_result : r);
      sentences_closed++;
      in_sent = 1'b0;
      return;
    end
    if (!star_seen) begin
      if (c == CharStar) star_seen = 1'b1;
      else run_xor = run_xor ^ c;
    end
    last_pair = {last_pair[7:0], c};
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      char_if.valid = 1'b0;
      @(negedge clk);
    end
    char_if.valid           = 1'b1;
    char_if.payload.char_in = c;
    do @(posedge clk); while (!char_if.ready);
    predict_nmea_byte(c);
    @(negedge clk);
  endtask

  task automatic set_length_limit(input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    len_limit = v;
  endtask

  task automatic settle_idle();
    char_if.valid = 1'b0;
    while (expected_sentences.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    if ($urandom_range(99) < 90) begin
      do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CharDollar || b == CharStar);
    end else begin
      do b = 8'($urandom_range(255));
      while (b == CharDollar || b == CharStar || b == CharCr);
    end
    return b;
  endfunction

  task automatic send_random_burst();
    int         kind;
    int         body_len;
    int         n;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 88) begin
      n = $urandom_range(99);
      if (n < 80) body_len = $urandom_range(0, 8);
      else if (n < 96) body_len = $urandom_range(9, 85);
      else body_len = $urandom_range(240, 290);
      x = 8'h00;
      send_char(CharDollar);
      for (int i = 0; i < body_len; i++) begin
        b = body_byte();
        x = x ^ b;
        send_char(b);
      end
      if (kind < 65) begin
        send_char(CharStar);
        // Bytes after the first asterisk stay out of the sum.
        if ($urandom_range(4) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) send_char(body_byte());
        end
        send_char(hex_char(x[7:4]));
        send_char(hex_char(x[3:0]));
      end else if (kind < 75) begin
        y = x ^ 8'($urandom_range(1, 255));
        send_char(CharStar);
        send_char(hex_char(y[7:4]));
        send_char(hex_char(y[3:0]));
      end else if (kind < 82) begin
        do b = 8'($urandom_range(255)); while (b == CharDollar || b == CharCr);
        send_char(CharStar);
        if ($urandom_range(1) == 1) begin
          send_char(b);
          send_char(hex_char(x[3:0]));
        end else begin
          send_char(hex_char(x[7:4]));
          send_char(b);
        end
      end
      send_char(CharCr);
    end else if (kind < 94) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        do b = 8'($urandom_range(255)); while (b == CharDollar);
        send_char(b);
      end
    end else begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)));
      if ($urandom_range(1) == 1) send_char(CharCr);
    end
  endtask

  task automatic run_random(input int byte_goal, input int sentence_goal);
    int b0;
    int s0;
    b0 = useful_bytes;
    s0 = sentences_closed;
    while (useful_bytes - b0 < byte_goal || sentences_closed - s0 < sentence_goal)
      send_random_burst();
  endtask

  // Result side: ready is redrawn every falling edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    result_beat_t want;
    result_beat_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (expected_sentences.size() == 0) begin
        report_mismatch($sformatf("unexpected result ok=%0b status=%0d sum=%h rx=%h",
                                  got.sentence_ok, got.status, got.computed_sum,
                                  got.received_sum));
      end else begin
        want = expected_sentences.pop_front();
        if (got.sentence_ok !== want.sentence_ok || got.status !== want.status ||
            got.computed_sum !== want.computed_sum ||
            got.received_sum !== want.received_sum)
          report_mismatch($sformatf("got ok=%0b status=%0d sum=%h rx=%h, want %0b %0d %h %h",
                                    got.sentence_ok, got.status, got.computed_sum,
                                    got.received_sum, want.sentence_ok, want.status,
                                    want.computed_sum, want.received_sum));
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 8'h00;
    char_if.valid    = 1'b0;
    char_if.payload  = '0;
    in_sent          = 1'b0;
    star_seen        = 1'b0;
    run_xor          = 8'h00;
    len_cnt          = 8'h00;
    last_pair        = 16'h0000;
    len_limit        = MaxLenReset;
    use_typed        = 1'b0;
    typed_result     = '0;
    error_count      = 0;
    cycle_count      = 0;
    useful_bytes     = 0;
    sentences_closed = 0;
    send_idle        = 27;
    recv_idle        = 49;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      use_typed    = dir_rows[i].typed;
      typed_result = dir_rows[i].want;
      for (int k = 0; k < dir_rows[i].txt.len(); k++) send_char(dir_rows[i].txt[k]);
      send_char(dir_rows[i].tail);
      use_typed = 1'b0;
    end
    run_random(300, 12);

    settle_idle();
    send_idle = 49;
    recv_idle = 27;
    // At the top limit the saturated length counter never reports too long.
    set_length_limit(8'd255);
    run_random(300, 10);

    settle_idle();
    send_idle = 0;
    recv_idle = 0;
    set_length_limit(8'd0);
    run_random(40, 2);
    settle_idle();
    set_length_limit(8'd1);
    run_random(40, 2);
    settle_idle();
    set_length_limit(8'($urandom_range(2, 254)));
    run_random(250, 10);

    char_if.valid = 1'b0;
    for (int i = 0; i < 5000 && expected_sentences.size() != 0; i++) @(negedge clk);
    if (expected_sentences.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_sentences.size()));
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nmeacs_pkg.sv
hw/rtl/nmeacs_stream_if.sv
hw/rtl/nmeacs_out_buf.sv
hw/rtl/nmea_sentence_checksum_validator.sv
tb/tb_nmea_sentence_checksum_validator.sv
